FILE: src/cidhex_pkg.sv
`default_nettype none

package cidhex_pkg;

  // Default record length limit in non-zero bytes
  localparam int unsigned MaxBytesDef = 41;

  // Digits in the date and in the time field
  localparam int unsigned FieldLen = 4;

  // Field kinds on the result channel
  localparam logic [2:0] KIND_DATE  = 3'd0;
  localparam logic [2:0] KIND_TIME  = 3'd1;
  localparam logic [2:0] KIND_NAME  = 3'd2;
  localparam logic [2:0] KIND_PHONE = 3'd3;
  localparam logic [2:0] KIND_END   = 3'd4;

  // Character codes used by the parser
  localparam logic [7:0] CHR_P      = 8'h50;
  localparam logic [7:0] CHR_O      = 8'h4f;
  localparam logic [7:0] CHR_ZERO   = 8'h30;
  localparam logic [7:0] CHR_ONE    = 8'h31;
  localparam logic [7:0] CHR_NINE   = 8'h39;
  localparam logic [7:0] CHR_SPACE  = 8'h20;
  localparam logic [7:0] CHR_TILDE  = 8'h7e;

  // Replacement text lengths
  localparam logic [3:0] PRIV_LEN  = 4'd7;
  localparam logic [3:0] UNAV_LEN  = 4'd11;

  typedef struct packed {
    logic [7:0] hex_char;
    logic       final_char;
  } cidhex_in_t;

  typedef struct packed {
    logic [2:0] field_kind;
    logic [7:0] char_code;
    logic       run_last;
  } cidhex_out_t;

  // Decode one ASCII hex digit: {ok, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  function automatic logic is_print(input logic [7:0] b);
    return (b >= CHR_SPACE) && (b <= CHR_TILDE);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CHR_ZERO) && (b <= CHR_NINE);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5a)) || ((b >= 8'h61) && (b <= 8'h7a));
  endfunction

  // Character idx of PRIVATE (priv) or UNAVAILABLE
  function automatic logic [7:0] text_char(input logic priv, input logic [3:0] idx);
    logic [7:0] c;
    c = 8'h00;
    if (priv) begin
      unique case (idx)
        4'd0:    c = 8'h50;
        4'd1:    c = 8'h52;
        4'd2:    c = 8'h49;
        4'd3:    c = 8'h56;
        4'd4:    c = 8'h41;
        4'd5:    c = 8'h54;
        4'd6:    c = 8'h45;
        default: c = 8'h00;
      endcase
    end else begin
      unique case (idx)
        4'd0:    c = 8'h55;
        4'd1:    c = 8'h4e;
        4'd2:    c = 8'h41;
        4'd3:    c = 8'h56;
        4'd4:    c = 8'h41;
        4'd5:    c = 8'h49;
        4'd6:    c = 8'h4c;
        4'd7:    c = 8'h41;
        4'd8:    c = 8'h42;
        4'd9:    c = 8'h4c;
        4'd10:   c = 8'h45;
        default: c = 8'h00;
      endcase
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: src/caller_id_hex_record_parser_core.sv
// Caller ID hex record parser.
// Input channel (in_valid_i / in_ready_o / in_data_i): one ASCII character per
// beat, with final_char set on the last character of a record. Output channel
// (out_valid_o / out_ready_i / out_data_o): one result character per beat,
// tagged with its field kind; run_last marks the last beat caused by one
// input character, and the final character always adds an end-of-record beat.
// Each accepted character updates the parser state in the same cycle and
// loads a result descriptor; its first result beat is visible the next cycle.
// A character that causes one or no beat leaves the input ready, so one
// character per cycle flows as long as the receiver takes every beat.
// A character that expands to replacement text (PRIVATE or UNAVAILABLE, plus
// an end beat) occupies the descriptor for up to 12 beats, and the input
// accepts the next character on the cycle the last of those beats is taken.
// When the receiver stalls, the pending beat holds and the input stays ready
// only on a cycle that takes the last beat of the descriptor.
// Reset clears the pairing, byte count and parse phase, and drops any
// pending beats; the block is ready in the first cycle after reset.
`default_nettype none

module caller_id_hex_record_parser_core #(
  parameter int unsigned MAX_BYTES = cidhex_pkg::MaxBytesDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output      logic                   in_ready_o,
  input  wire cidhex_pkg::cidhex_in_t  in_data_i,
  output      logic                   out_valid_o,
  input  wire logic                   out_ready_i,
  output      cidhex_pkg::cidhex_out_t out_data_o
);
  import cidhex_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_BYTES + 1);

  typedef enum logic [8:0] {
    PH_SEEK      = 9'b000000001,
    PH_DATE      = 9'b000000010,
    PH_TIME      = 9'b000000100,
    PH_PRE_NAME  = 9'b000001000,
    PH_NAME      = 9'b000010000,
    PH_SWALLOW   = 9'b000100000,
    PH_PRE_PHONE = 9'b001000000,
    PH_PHONE     = 9'b010000000,
    PH_DONE      = 9'b100000000
  } phase_e;

  // Result descriptor for one input beat
  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] nch;
    logic [7:0] c0;
    logic [7:0] c1;
    logic       text_en;
    logic       text_priv;
    logic [3:0] n_beats;
  } desc_t;

  // Parser state
  logic            nib_wait_q, nib_wait_d;
  logic [3:0]      hi_nib_q, hi_nib_d;
  logic            hi_ok_q, hi_ok_d;
  logic [CntW-1:0] taken_q, taken_d;
  phase_e          phase_q, phase_d;
  logic [2:0]      cnt_q, cnt_d;
  logic [7:0]      held_chr_q, held_chr_d;
  logic            held_q, held_d;
  logic            ph_begun_q, ph_begun_d;
  logic            ph_repl_q, ph_repl_d;

  // Descriptor and beat sequencer
  desc_t           desc_q, desc_d;
  logic            desc_vld_q, desc_vld_d;
  logic [3:0]      idx_q, idx_d;

  logic            in_acc, out_acc, beat_last;
  logic [4:0]      hex_dec;
  logic            hex_ok;
  logic [3:0]      hex_val;
  logic [7:0]      byte_s;
  logic            take_s;
  logic            phone_go;
  logic            repl_s;
  logic [7:0]      second_s;
  logic [3:0]      text_len;
  logic [3:0]      out_text_len;

  assign hex_dec = hex_decode(in_data_i.hex_char);
  assign hex_ok  = hex_dec[4];
  assign hex_val = hex_dec[3:0];

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Next parser state and descriptor for the beat on the input
  always_comb begin
    nib_wait_d = nib_wait_q;
    hi_nib_d   = hi_nib_q;
    hi_ok_d    = hi_ok_q;
    taken_d    = taken_q;
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    held_chr_d = held_chr_q;
    held_d     = held_q;
    ph_begun_d = ph_begun_q;
    ph_repl_d  = ph_repl_q;
    byte_s     = 8'h00;
    take_s     = 1'b0;
    phone_go   = 1'b0;
    repl_s     = 1'b0;
    second_s   = 8'h00;
    text_len   = 4'd0;
    desc_d     = '0;
    desc_d.kind = KIND_DATE;

    // Pair characters into bytes
    if (nib_wait_q) begin
      byte_s = !hi_ok_q ? 8'h00 : (hex_ok ? {hi_nib_q, hex_val} : {4'h0, hi_nib_q});
      take_s = 1'b1;
      nib_wait_d = 1'b0;
      hi_nib_d   = 4'h0;
      hi_ok_d    = 1'b0;
    end else if (in_data_i.final_char) begin
      byte_s = hex_ok ? {4'h0, hex_val} : 8'h00;
      take_s = 1'b1;
    end else begin
      nib_wait_d = 1'b1;
      hi_ok_d    = hex_ok;
      hi_nib_d   = hex_ok ? hex_val : 4'h0;
    end

    // Advance the field parser on a counted non-zero byte
    if (take_s && (byte_s != 8'h00) && (taken_q < CntW'(MAX_BYTES))) begin
      taken_d = taken_q + CntW'(1);
      unique case (phase_q)
        PH_SEEK: begin
          if (is_digit(byte_s)) begin
            desc_d.kind = KIND_DATE;
            desc_d.nch  = 2'd1;
            desc_d.c0   = byte_s;
            cnt_d       = 3'd1;
            phase_d     = PH_DATE;
          end
        end
        PH_DATE: begin
          desc_d.kind = KIND_DATE;
          desc_d.nch  = 2'd1;
          desc_d.c0   = byte_s;
          if (cnt_q == 3'(FieldLen - 1)) begin
            cnt_d   = 3'd0;
            phase_d = PH_TIME;
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
        PH_TIME: begin
          desc_d.kind = KIND_TIME;
          desc_d.nch  = 2'd1;
          desc_d.c0   = byte_s;
          if (cnt_q == 3'(FieldLen - 1)) begin
            cnt_d   = 3'd0;
            phase_d = PH_PRE_NAME;
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
        PH_PRE_NAME: begin
          if (is_print(byte_s)) begin
            phase_d = PH_NAME;
            if ((byte_s == CHR_P) || (byte_s == CHR_O)) begin
              held_chr_d = byte_s;
              held_d     = 1'b1;
            end else begin
              desc_d.kind = KIND_NAME;
              desc_d.nch  = 2'd1;
              desc_d.c0   = byte_s;
            end
          end
        end
        PH_NAME: begin
          desc_d.kind = KIND_NAME;
          if (held_q) begin
            // Decide on the held leading P or O
            second_s = is_print(byte_s) ? byte_s : 8'h00;
            if (held_chr_q == CHR_P) begin
              repl_s = !(is_alpha(second_s) || is_digit(second_s));
            end else begin
              repl_s = !(is_alpha(second_s) ||
                         ((second_s >= CHR_ONE) && (second_s <= CHR_NINE)));
            end
            held_d     = 1'b0;
            held_chr_d = 8'h00;
            if (repl_s) begin
              desc_d.text_en   = 1'b1;
              desc_d.text_priv = (held_chr_q == CHR_P);
              phase_d = is_print(byte_s) ? PH_SWALLOW : PH_PRE_PHONE;
            end else begin
              desc_d.nch = 2'd2;
              desc_d.c0  = held_chr_q;
              desc_d.c1  = byte_s;
            end
          end else if (is_print(byte_s)) begin
            desc_d.nch = 2'd1;
            desc_d.c0  = byte_s;
          end else begin
            phase_d = PH_PRE_PHONE;
          end
        end
        PH_SWALLOW: begin
          if (!is_print(byte_s)) begin
            phase_d = PH_PRE_PHONE;
          end
        end
        PH_PRE_PHONE: begin
          if (is_print(byte_s)) begin
            phase_d  = PH_PHONE;
            phone_go = 1'b1;
          end
        end
        PH_PHONE: begin
          phone_go = 1'b1;
        end
        PH_DONE: begin
          phase_d = PH_DONE;
        end
        default: begin
          phase_d = PH_DONE;
        end
      endcase

      // Keep phone digits, O and P; replace a leading O or P
      if (phone_go) begin
        desc_d.kind = KIND_PHONE;
        if (!is_print(byte_s)) begin
          phase_d = PH_DONE;
        end else if ((is_digit(byte_s) || (byte_s == CHR_O) || (byte_s == CHR_P)) &&
                     !ph_repl_q) begin
          ph_begun_d = 1'b1;
          if (!ph_begun_q && ((byte_s == CHR_P) || (byte_s == CHR_O))) begin
            ph_repl_d        = 1'b1;
            desc_d.text_en   = 1'b1;
            desc_d.text_priv = (byte_s == CHR_P);
          end else begin
            desc_d.nch = 2'd1;
            desc_d.c0  = byte_s;
          end
        end
      end
    end

    // Close the record on the final character
    if (in_data_i.final_char) begin
      if ((phase_d == PH_NAME) && held_d) begin
        desc_d.kind      = KIND_NAME;
        desc_d.text_en   = 1'b1;
        desc_d.text_priv = (held_chr_d == CHR_P);
      end
      nib_wait_d = 1'b0;
      hi_nib_d   = 4'h0;
      hi_ok_d    = 1'b0;
      taken_d    = '0;
      phase_d    = PH_SEEK;
      cnt_d      = 3'd0;
      held_chr_d = 8'h00;
      held_d     = 1'b0;
      ph_begun_d = 1'b0;
      ph_repl_d  = 1'b0;
    end

    // Count the beats of this descriptor
    if (desc_d.text_en) begin
      text_len = desc_d.text_priv ? PRIV_LEN : UNAV_LEN;
    end else begin
      text_len = {2'b00, desc_d.nch};
    end
    desc_d.n_beats = text_len + {3'b000, in_data_i.final_char};
  end

  // Select the current beat from the descriptor
  assign out_text_len = desc_q.text_priv ? PRIV_LEN : UNAV_LEN;
  assign beat_last    = (idx_q == (desc_q.n_beats - 4'd1));

  always_comb begin
    out_data_o.run_last = beat_last;
    if (desc_q.text_en && (idx_q < out_text_len)) begin
      out_data_o.field_kind = desc_q.kind;
      out_data_o.char_code  = text_char(desc_q.text_priv, idx_q);
    end else if (!desc_q.text_en && (idx_q < {2'b00, desc_q.nch})) begin
      out_data_o.field_kind = desc_q.kind;
      out_data_o.char_code  = idx_q[0] ? desc_q.c1 : desc_q.c0;
    end else begin
      out_data_o.field_kind = KIND_END;
      out_data_o.char_code  = 8'h00;
    end
  end

  assign out_valid_o = desc_vld_q;
  assign in_ready_o  = !desc_vld_q || (out_ready_i && beat_last);

  // Load a descriptor on input, drop it after its last beat
  always_comb begin
    desc_vld_d = desc_vld_q;
    idx_d      = idx_q;
    if (out_acc) begin
      idx_d = beat_last ? 4'd0 : (idx_q + 4'd1);
      if (beat_last) begin
        desc_vld_d = 1'b0;
      end
    end
    if (in_acc) begin
      desc_vld_d = (desc_d.n_beats != 4'd0);
      idx_d      = 4'd0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nib_wait_q <= 1'b0;
      hi_nib_q   <= 4'h0;
      hi_ok_q    <= 1'b0;
      taken_q    <= '0;
      phase_q    <= PH_SEEK;
      cnt_q      <= 3'd0;
      held_chr_q <= 8'h00;
      held_q     <= 1'b0;
      ph_begun_q <= 1'b0;
      ph_repl_q  <= 1'b0;
      desc_vld_q <= 1'b0;
      idx_q      <= 4'd0;
    end else begin
      desc_vld_q <= desc_vld_d;
      idx_q      <= idx_d;
      if (in_acc) begin
        nib_wait_q <= nib_wait_d;
        hi_nib_q   <= hi_nib_d;
        hi_ok_q    <= hi_ok_d;
        taken_q    <= taken_d;
        phase_q    <= phase_d;
        cnt_q      <= cnt_d;
        held_chr_q <= held_chr_d;
        held_q     <= held_d;
        ph_begun_q <= ph_begun_d;
        ph_repl_q  <= ph_repl_d;
      end
    end
  end

  // Descriptor payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      desc_q <= desc_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/cidhex_chk.sv
`default_nettype none

module cidhex_chk (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_ready_o,
  input wire cidhex_pkg::cidhex_in_t  in_data_i,
  input wire logic                    out_valid_o,
  input wire logic                    out_ready_i,
  input wire cidhex_pkg::cidhex_out_t out_data_o
);
  import cidhex_pkg::*;

  // An end-of-record beat closes its run and carries no character
  a_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.field_kind == KIND_END)) |->
      (out_data_o.run_last && (out_data_o.char_code == 8'h00)))
    else $error("end beat without run_last or with a character");

  // Field kind stays within the defined codes
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((out_data_o.field_kind == KIND_DATE) || (out_data_o.field_kind == KIND_TIME) ||
       (out_data_o.field_kind == KIND_NAME) || (out_data_o.field_kind == KIND_PHONE) ||
       (out_data_o.field_kind == KIND_END)))
    else $error("undefined field kind");

  // Input backpressure only while a result beat is pending
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result beat changed while stalled");

  // A stalled input beat holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=> (in_valid_i && $stable(in_data_i)))
    else $error("input beat changed while stalled");

endmodule

bind caller_id_hex_record_parser_core cidhex_chk u_cidhex_chk (.*);

`default_nettype wire

FILE: sim/tb_caller_id_hex_record_parser_core.sv
`timescale 1ns / 1ps

module tb_caller_id_hex_record_parser_core;
  import cidhex_pkg::*;

  localparam int unsigned MaxBytes    = MaxBytesDef;
  localparam int unsigned MaxBeats    = 12;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 30;
  localparam int unsigned LongHold    = 200;

  typedef enum logic [3:0] {
    SEEK_DIGIT, DATE_RUN, TIME_RUN, NAME_WAIT, NAME_RUN, NAME_SKIP,
    PHONE_WAIT, PHONE_RUN, REC_DONE
  } parse_phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  cidhex_in_t  in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  cidhex_out_t out_data;

  // Mode flags for the stimulus and ready processes, and run counters
  bit          steady = 1'b0;
  bit          hold_off_req = 1'b0;
  int unsigned chars_sent = 0;
  int unsigned errors = 0;

  // Parser state mirrored by the prediction
  logic         pair_open;
  logic [3:0]   pair_nib;
  logic         pair_ok;
  int unsigned  bytes_seen;
  parse_phase_e phase;
  int unsigned  field_cnt;
  logic [7:0]   held_c;
  logic         held;
  logic         phone_begun;
  logic         phone_subst;

  cidhex_out_t  char_beats[$];
  cidhex_out_t  beats_due[$];
  cidhex_out_t  want_beat;
  logic [7:0]   rec_bytes[$];

  caller_id_hex_record_parser_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Character classes
  function automatic int nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h37;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h57;
    return -1;
  endfunction

  function automatic logic printable(input logic [7:0] b);
    return (b >= CHR_SPACE) && (b <= CHR_TILDE);
  endfunction

  function automatic logic decimal(input logic [7:0] b);
    return (b >= CHR_ZERO) && (b <= CHR_NINE);
  endfunction

  function automatic logic letter(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a);
  endfunction

  // Append one beat of the current character, capped at the beat limit
  function automatic void emit(input logic [2:0] kind, input logic [7:0] code);
    cidhex_out_t b;
    b.field_kind = kind;
    b.char_code  = code;
    b.run_last   = 1'b0;
    if (char_beats.size() < MaxBeats) char_beats.push_back(b);
  endfunction

  function automatic void emit_text(input logic [2:0] kind, input logic priv);
    string txt;
    txt = priv ? "PRIVATE" : "UNAVAILABLE";
    for (int i = 0; i < txt.len(); i++) emit(kind, txt[i]);
  endfunction

  function automatic void clear_parser();
    pair_open = 1'b0; pair_nib = '0; pair_ok = 1'b0; bytes_seen = 0;
    phase = SEEK_DIGIT; field_cnt = 0; held_c = '0; held = 1'b0;
    phone_begun = 1'b0; phone_subst = 1'b0;
  endfunction

  // Keep digits, O and P of the phone run; a leading O or P becomes text
  function automatic void phone_take(input logic [7:0] b);
    if (!printable(b)) begin
      phase = REC_DONE;
      return;
    end
    if (!(decimal(b) || b == CHR_O || b == CHR_P)) return;
    if (phone_subst) return;
    if (!phone_begun) begin
      phone_begun = 1'b1;
      if (b == CHR_P || b == CHR_O) begin
        phone_subst = 1'b1;
        emit_text(KIND_PHONE, b == CHR_P);
        return;
      end
    end
    emit(KIND_PHONE, b);
  endfunction

  // Advance the field parser by one decoded byte
  function automatic void absorb_byte(input logic [7:0] b);
    logic [7:0] second;
    logic       swap;
    if (b == 8'h00 || bytes_seen >= MaxBytes) return;
    bytes_seen++;
    case (phase)
      SEEK_DIGIT: begin
        if (decimal(b)) begin
          emit(KIND_DATE, b);
          field_cnt = 1;
          phase = DATE_RUN;
        end
      end
      DATE_RUN: begin
        emit(KIND_DATE, b);
        field_cnt++;
        if (field_cnt >= FieldLen) begin
          field_cnt = 0;
          phase = TIME_RUN;
        end
      end
      TIME_RUN: begin
        emit(KIND_TIME, b);
        field_cnt++;
        if (field_cnt >= FieldLen) begin
          field_cnt = 0;
          phase = NAME_WAIT;
        end
      end
      NAME_WAIT: begin
        if (printable(b)) begin
          phase = NAME_RUN;
          if (b == CHR_P || b == CHR_O) begin
            held_c = b;
            held = 1'b1;
          end else begin
            emit(KIND_NAME, b);
          end
        end
      end
      NAME_RUN: begin
        if (held) begin
          // Decide whether the held P or O opens a withheld name
          second = printable(b) ? b : 8'h00;
          held = 1'b0;
          if (held_c == CHR_P) swap = !(letter(second) || decimal(second));
          else swap = !(letter(second) || (second >= CHR_ONE && second <= CHR_NINE));
          if (swap) begin
            emit_text(KIND_NAME, held_c == CHR_P);
            phase = printable(b) ? NAME_SKIP : PHONE_WAIT;
          end else begin
            emit(KIND_NAME, held_c);
            emit(KIND_NAME, b);
          end
          held_c = 8'h00;
        end else if (printable(b)) begin
          emit(KIND_NAME, b);
        end else begin
          phase = PHONE_WAIT;
        end
      end
      NAME_SKIP: begin
        if (!printable(b)) phase = PHONE_WAIT;
      end
      PHONE_WAIT: begin
        if (printable(b)) begin
          phase = PHONE_RUN;
          phone_take(b);
        end
      end
      PHONE_RUN: phone_take(b);
      default: phase = REC_DONE;
    endcase
  endfunction

  // Work out the beats caused by one accepted character and queue them
  function automatic void parse_char(input cidhex_in_t it);
    int          nv;
    logic [7:0]  byte_v;
    cidhex_out_t tail;
    char_beats.delete();
    nv = nibble_of(it.hex_char);
    if (pair_open) begin
      if (!pair_ok) byte_v = 8'h00;
      else if (nv < 0) byte_v = {4'h0, pair_nib};
      else byte_v = {pair_nib, nv[3:0]};
      pair_open = 1'b0; pair_nib = '0; pair_ok = 1'b0;
      absorb_byte(byte_v);
    end else if (it.final_char) begin
      absorb_byte(nv < 0 ? 8'h00 : {4'h0, nv[3:0]});
    end else begin
      pair_open = 1'b1;
      pair_ok = (nv >= 0);
      pair_nib = (nv < 0) ? 4'h0 : nv[3:0];
    end
    if (it.final_char) begin
      if (phase == NAME_RUN && held) emit_text(KIND_NAME, held_c == CHR_P);
      emit(KIND_END, 8'h00);
      clear_parser();
    end
    if (char_beats.size() > 0) begin
      tail = char_beats.pop_back();
      tail.run_last = 1'b1;
      char_beats.push_back(tail);
    end
    foreach (char_beats[i]) beats_due.push_back(char_beats[i]);
  endfunction

  // Random byte and character sources
  function automatic logic [7:0] rand_print();
    return 8'($urandom_range(8'h20, 8'h7e));
  endfunction

  function automatic logic [7:0] rand_nonprint();
    int r;
    r = $urandom_range(0, 159);
    return (r < 31) ? 8'(r + 1) : 8'(r + 96);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'($urandom_range(8'h30, 8'h39));
  endfunction

  function automatic logic [7:0] rand_punct();
    logic [7:0] b;
    do b = rand_print(); while (letter(b) || decimal(b));
    return b;
  endfunction

  function automatic logic [7:0] rand_p_or_o();
    return $urandom_range(0, 1) ? CHR_P : CHR_O;
  endfunction

  function automatic logic [7:0] rand_nonhex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (nibble_of(c) >= 0);
    return c;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    if (n < 4'd10) return CHR_ZERO + 8'(n);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  // Build the bytes of one caller ID record with random content
  function automatic void build_record(input bit long_name);
    int         n;
    int         v;
    int         cut;
    bit         trunc;
    logic [7:0] b;
    rec_bytes.delete();
    trunc = 1'b0;
    n = $urandom_range(0, 2);
    repeat (n) begin
      do b = 8'($urandom_range(1, 255)); while (decimal(b));
      rec_bytes.push_back(b);
    end
    // Date and time; the first digit opens the date
    rec_bytes.push_back(rand_digit());
    for (int i = 1; i < 8; i++) begin
      rec_bytes.push_back(($urandom_range(0, 15) == 0) ? rand_print() : rand_digit());
    end
    repeat ($urandom_range(1, 2)) rec_bytes.push_back(rand_nonprint());
    v = long_name ? 8 : $urandom_range(0, 7);
    case (v)
      0, 1, 2: repeat ($urandom_range(1, 5)) rec_bytes.push_back(rand_print());
      3: rec_bytes.push_back(CHR_P);
      4: begin
        rec_bytes.push_back(rand_p_or_o());
        rec_bytes.push_back(rand_punct());
        repeat ($urandom_range(0, 3)) rec_bytes.push_back(rand_print());
      end
      5: begin
        rec_bytes.push_back(CHR_O);
        rec_bytes.push_back(CHR_ZERO);
        repeat ($urandom_range(0, 3)) rec_bytes.push_back(rand_print());
      end
      6: begin
        rec_bytes.push_back(rand_p_or_o());
        rec_bytes.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h41, 8'h5a)) :
                            8'($urandom_range(8'h31, 8'h39)));
        repeat ($urandom_range(0, 3)) rec_bytes.push_back(rand_print());
      end
      7: begin
        rec_bytes.push_back(rand_p_or_o());
        trunc = 1'b1;
      end
      default: repeat (40) rec_bytes.push_back(rand_print());
    endcase
    if (!trunc) begin
      repeat ($urandom_range(1, 2)) rec_bytes.push_back(rand_nonprint());
      v = $urandom_range(0, 5);
      if (v <= 3) begin
        rec_bytes.push_back(rand_digit());
        repeat ($urandom_range(0, 5)) begin
          n = $urandom_range(0, 7);
          if (n == 0) rec_bytes.push_back(rand_print());
          else if (n == 1) rec_bytes.push_back(rand_p_or_o());
          else rec_bytes.push_back(rand_digit());
        end
      end else if (v == 4) begin
        rec_bytes.push_back(rand_p_or_o());
        repeat ($urandom_range(0, 3)) rec_bytes.push_back(rand_print());
      end else begin
        rec_bytes.push_back(rand_punct());
        rec_bytes.push_back(rand_p_or_o());
        repeat ($urandom_range(0, 3)) rec_bytes.push_back(rand_digit());
      end
      repeat ($urandom_range(0, 2)) rec_bytes.push_back(8'($urandom_range(1, 255)));
      // Cut some records short
      if (!long_name && $urandom_range(0, 5) == 0) begin
        cut = $urandom_range(1, rec_bytes.size());
        while (rec_bytes.size() > cut) void'(rec_bytes.pop_back());
      end
    end
  endfunction

  // Offer one character, after a random gap unless steady, hold it until accepted
  task automatic send_char(input logic [7:0] c, input logic fin);
    int         gap;
    cidhex_in_t it;
    it.hex_char = c;
    it.final_char = fin;
    gap = steady ? 0 : $urandom_range(0, 10);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk_i); while (!in_ready);
    parse_char(it);
    chars_sent++;
  endtask

  // Hex-encode the record bytes with occasional broken pairs and zero bytes
  task automatic send_record();
    logic [7:0] b;
    logic [7:0] hi_c;
    logic [7:0] lo_c;
    int         mode;
    bit         odd_tail;
    odd_tail = ($urandom_range(0, 2) == 0) || (rec_bytes.size() == 0);
    for (int i = 0; i < rec_bytes.size(); i++) begin
      b = rec_bytes[i];
      if ($urandom_range(0, 23) == 0) begin
        send_char(CHR_ZERO, 1'b0);
        send_char(CHR_ZERO, 1'b0);
      end
      mode = $urandom_range(0, 19);
      hi_c = (mode == 0) ? rand_nonhex() : hex_digit(b[7:4]);
      lo_c = (mode == 1) ? rand_nonhex() : hex_digit(b[3:0]);
      send_char(hi_c, 1'b0);
      send_char(lo_c, (i == rec_bytes.size() - 1) && !odd_tail);
    end
    if (odd_tail) begin
      send_char($urandom_range(0, 1) ? hex_digit(4'($urandom_range(0, 15))) : rand_nonhex(),
                1'b1);
    end
  endtask

  // Pairing rules, lone and non-hex characters, extreme codes
  task automatic test_pairing();
    steady = 1'b0;
    send_char(8'h37, 1'b1);
    send_char(8'h00, 1'b1);
    send_char(8'hff, 1'b1);
    send_char(8'h33, 1'b0);
    send_char(8'h39, 1'b0);
    send_char(8'h78, 1'b0);
    send_char(8'h41, 1'b0);
    send_char(8'h41, 1'b0);
    send_char(8'hff, 1'b0);
    send_char(CHR_ZERO, 1'b0);
    send_char(CHR_ZERO, 1'b0);
    send_char(8'h66, 1'b0);
    send_char(8'h46, 1'b0);
    send_char(8'h33, 1'b0);
    send_char(8'h31, 1'b0);
    send_char(8'h34, 1'b0);
    send_char(8'h32, 1'b0);
    send_char(8'h65, 1'b1);
    send_char(8'h33, 1'b0);
    send_char(8'h35, 1'b1);
    send_char(8'h47, 1'b0);
    send_char(8'h61, 1'b1);
  endtask

  // Random records with name and phone variants, some cut short
  task automatic test_records();
    int unsigned stop_at;
    stop_at = chars_sent + 20;
    while (chars_sent < stop_at) begin
      steady = ($urandom_range(0, 3) == 0);
      build_record(1'b0);
      send_record();
    end
    steady = 1'b0;
  endtask

  // Long name run that crosses the record byte limit
  task automatic test_byte_limit();
    steady = 1'b0;
    build_record(1'b1);
    send_record();
  endtask

  // Long receiver stall while characters keep coming back to back
  task automatic test_backpressure();
    steady = 1'b1;
    hold_off_req = 1'b1;
    build_record(1'b0);
    send_record();
    steady = 1'b0;
  endtask

  // Random characters with random record ends
  task automatic test_noise();
    repeat (15) send_char(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
    send_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Drive the result ready: random stalls, one long hold when asked
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        stall = LongHold;
        hold_off_req = 1'b0;
      end else begin
        stall = steady ? 0 : $urandom_range(0, 10);
      end
      repeat (stall) begin
        @(negedge clk_i);
        out_ready = 1'b0;
      end
      @(negedge clk_i);
      out_ready = 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  // Compare each accepted beat with the oldest expected one
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (beats_due.size() == 0) begin
        $error("unexpected beat: field_kind %0d char_code 0x%02h run_last %0d",
               out_data.field_kind, out_data.char_code, out_data.run_last);
        errors++;
      end else begin
        want_beat = beats_due.pop_front();
        if (out_data.field_kind !== want_beat.field_kind) begin
          $error("field_kind: expected %0d, got %0d", want_beat.field_kind,
                 out_data.field_kind);
          errors++;
        end
        if (out_data.char_code !== want_beat.char_code) begin
          $error("char_code: expected 0x%02h, got 0x%02h", want_beat.char_code,
                 out_data.char_code);
          errors++;
        end
        if (out_data.run_last !== want_beat.run_last) begin
          $error("run_last: expected %0d, got %0d", want_beat.run_last,
                 out_data.run_last);
          errors++;
        end
      end
    end
  end

  // Stop a hung run
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    clear_parser();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_pairing();
    test_records();
    test_byte_limit();
    test_backpressure();
    test_noise();
    @(negedge clk_i);
    in_valid = 1'b0;
    // Drain the remaining beats
    while (beats_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
